@@ sv/lcp_pkg.sv @@
package lcp_pkg;

   // line store depth default
   localparam int LINE_BYTES_DEF = 12;

   // received byte count saturates here
   localparam int COUNT_W   = 4;
   localparam int COUNT_MAX = 14;

   // result kinds
   localparam logic [1:0] KIND_ECHO   = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // command status codes
   localparam logic [1:0] STAT_NONE    = 2'd0;
   localparam logic [1:0] STAT_COLOUR  = 2'd1;
   localparam logic [1:0] STAT_RAINBOW = 2'd2;
   localparam logic [1:0] STAT_FORMAT  = 2'd3;

   // sequence positions of the back end: echo, 20 frame words, status
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_ECHO        = 5'd0;
   localparam logic [POS_W-1:0] POS_FRAME_FIRST = 5'd1;
   localparam logic [POS_W-1:0] POS_FRAME_LAST  = 5'd20;
   localparam logic [POS_W-1:0] POS_STATUS      = 5'd21;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // one job: everything the back end sends for one accepted word
   typedef struct packed {
      logic            has_echo;
      logic [7:0]      echo_byte;
      logic            has_frame;
      logic [8:0][7:0] rgb;        // R6 G6 B6 R7 G7 B7 R8 G8 B8
      logic            has_status;
      logic [1:0]      status;
   } job_type;

endpackage

@@ sv/lcp_if.sv @@
interface lcp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface lcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output kind, output data_byte, output status,
                   output last, input ready);
   modport sink (input valid, input kind, input data_byte, input status,
                 input last, output ready);
endinterface

@@ sv/lcp_front.sv @@
module lcp_front
   import lcp_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   lcp_req_if.sink req,
   output logic    push,
   output job_type push_job,
   input  logic    queue_full
);

   localparam int IDX_W = $clog2(LINE_BYTES);

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_6    = 8'h36;
   localparam logic [7:0] CHAR_8    = 8'h38;
   localparam logic [7:0] TICK_LAST = 8'd254;
   localparam logic [7:0] WHEEL_ONE = 8'd85;
   localparam logic [7:0] WHEEL_TWO = 8'd170;
   localparam logic [COUNT_W-1:0] COUNT_RAINBOW = 4'd13;
   localparam logic [COUNT_W-1:0] COUNT_COLOUR  = 4'd10;
   localparam logic [11:0][7:0] RAINBOW_TEXT = {
      8'h57, 8'h4F, 8'h42, 8'h4E, 8'h49, 8'h41,
      8'h52, 8'h4C, 8'h4C, 8'h55, 8'h46, 8'h23
   };

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [7:0] v;
      v = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

   logic [LINE_BYTES-1:0][7:0] line_ff, line_in;
   logic [COUNT_W-1:0]         count_ff, count_in, count_next;
   logic [8:0][7:0]            colour_ff, colour_in, colour_upd;
   logic                       rainbow_ff, rainbow_in;
   logic [7:0]                 tick_ff, tick_in, tick_next;

   logic             accept;
   logic             colour_ok, rainbow_ok;
   logic [1:0]       led;
   logic [7:0]       wp, wq, wr, wg, wb;
   logic [9:0]       wq3;
   logic [IDX_W-1:0] wr_idx;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // command checks on the stored line
      colour_ok = (line_ff[0] == CHAR_HASH) && (line_ff[7] == CHAR_D)
                  && (line_ff[8] >= CHAR_6) && (line_ff[8] <= CHAR_8);
      for (int i = 1; i < 7; i++) begin
         colour_ok = colour_ok && is_hex(line_ff[i]);
      end
      rainbow_ok = 1'b1;
      for (int i = 0; i < 12; i++) begin
         rainbow_ok = rainbow_ok && (line_ff[i] == RAINBOW_TEXT[i]);
      end

      led = 2'(line_ff[8] - CHAR_6);
      colour_upd = colour_ff;
      for (int l = 0; l < 3; l++) begin
         if (led == 2'(l)) begin
            colour_upd[l*3]   = {nibble(line_ff[1]), nibble(line_ff[2])};
            colour_upd[l*3+1] = {nibble(line_ff[3]), nibble(line_ff[4])};
            colour_upd[l*3+2] = {nibble(line_ff[5]), nibble(line_ff[6])};
         end
      end

      // tick counter wraps from 254 to 0
      tick_next  = (tick_ff == TICK_LAST) ? '0 : tick_ff + 8'd1;
      count_next = (count_ff < COUNT_W'(COUNT_MAX)) ? count_ff + 4'd1 : count_ff;
      wr_idx     = IDX_W'(count_next - 4'd1);

      // color wheel for the new tick value
      wp = 8'd255 - tick_next;
      if (wp < WHEEL_ONE) begin
         wq = wp;
      end else if (wp < WHEEL_TWO) begin
         wq = wp - WHEEL_ONE;
      end else begin
         wq = wp - WHEEL_TWO;
      end
      wq3 = {2'b00, wq} + {1'b0, wq, 1'b0};
      if (wp < WHEEL_ONE) begin
         wr = 8'd255 - wq3[7:0];
         wg = '0;
         wb = wq3[7:0];
      end else if (wp < WHEEL_TWO) begin
         wr = '0;
         wg = wq3[7:0];
         wb = 8'd255 - wq3[7:0];
      end else begin
         wr = wq3[7:0];
         wg = 8'd255 - wq3[7:0];
         wb = '0;
      end

      line_in    = line_ff;
      count_in   = count_ff;
      colour_in  = colour_ff;
      rainbow_in = rainbow_ff;
      tick_in    = tick_ff;
      push       = 1'b0;
      push_job   = '0;

      if (accept) begin
         if (req.func) begin
            tick_in = tick_next;
            if (rainbow_ff) begin
               push               = 1'b1;
               push_job.has_frame = 1'b1;
               for (int l = 0; l < 3; l++) begin
                  push_job.rgb[l*3]   = wr;
                  push_job.rgb[l*3+1] = wg;
                  push_job.rgb[l*3+2] = wb;
               end
            end
         end else begin
            count_in           = count_next;
            push               = 1'b1;
            push_job.has_echo  = 1'b1;
            push_job.echo_byte = req.rx_byte;
            if (int'(count_next) <= LINE_BYTES) begin
               line_in[wr_idx] = req.rx_byte;
            end
            if (req.rx_byte == CHAR_CR) begin
               push_job.has_status = 1'b1;
               push_job.status     = STAT_FORMAT;
               if (count_next == COUNT_RAINBOW && rainbow_ok) begin
                  rainbow_in      = 1'b1;
                  push_job.status = STAT_RAINBOW;
               end else if (count_next == COUNT_COLOUR && colour_ok) begin
                  colour_in          = colour_upd;
                  rainbow_in         = 1'b0;
                  push_job.has_frame = 1'b1;
                  push_job.rgb       = colour_upd;
                  push_job.status    = STAT_COLOUR;
               end
               line_in  = '0;
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= '0;
         count_ff   <= '0;
         colour_ff  <= '0;
         rainbow_ff <= 1'b0;
         tick_ff    <= '0;
      end else begin
         line_ff    <= line_in;
         count_ff   <= count_in;
         colour_ff  <= colour_in;
         rainbow_ff <= rainbow_in;
         tick_ff    <= tick_in;
      end
   end

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(COUNT_MAX))
      else $error("received count beyond saturation");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("job pushed into a full queue");

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff != 8'd255)
      else $error("tick counter out of range");

endmodule

@@ sv/lcp_queue.sv @@
module lcp_queue
   import lcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   function automatic logic [QPTR_W-1:0] ptr_step(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

endmodule

@@ sv/lcp_back.sv @@
module lcp_back
   import lcp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  job_type   pop_job,
   input  logic      empty,
   output logic      pop,
   lcp_rsp_if.source rsp
);

   logic             active_ff, active_in;
   job_type          job_ff, job_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       data_ff, data_in;
   logic [1:0]       status_ff, status_in;
   logic             last_ff, last_in;

   logic             advance, done_next;
   logic [POS_W-1:0] pos_follow, start_pos, f;
   logic [3:0]       g, rgb_idx;
   logic [7:0]       frame_byte;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = kind_ff;
   assign rsp.data_byte = data_ff;
   assign rsp.status    = status_ff;
   assign rsp.last      = last_ff;

   assign advance = active_ff && (!rsp_valid_ff || rsp.ready);
   assign pop     = !active_ff && !empty;

   always_comb begin
      // frame word for the current position
      f          = pos_ff - POS_FRAME_FIRST;
      g          = 4'(f - 5'd4);
      rgb_idx    = 4'({2'b00, g[3:2]} * 4'd3) + 4'd3 - {2'b00, g[1:0]};
      frame_byte = 8'hE1;
      if (f < 5'd4) begin
         frame_byte = 8'h00;
      end else if (f >= 5'd16) begin
         frame_byte = 8'hFF;
      end else if (g[1:0] != 2'd0) begin
         frame_byte = job_ff.rgb[rgb_idx];
      end

      // where the sequence goes after this word
      done_next  = 1'b0;
      pos_follow = pos_ff + 1'b1;
      if (pos_ff == POS_ECHO) begin
         if (job_ff.has_frame) begin
            pos_follow = POS_FRAME_FIRST;
         end else if (job_ff.has_status) begin
            pos_follow = POS_STATUS;
         end else begin
            done_next = 1'b1;
         end
      end else if (pos_ff == POS_FRAME_LAST) begin
         if (job_ff.has_status) begin
            pos_follow = POS_STATUS;
         end else begin
            done_next = 1'b1;
         end
      end else if (pos_ff == POS_STATUS) begin
         done_next = 1'b1;
      end

      if (pop_job.has_echo) begin
         start_pos = POS_ECHO;
      end else if (pop_job.has_frame) begin
         start_pos = POS_FRAME_FIRST;
      end else begin
         start_pos = POS_STATUS;
      end

      active_in    = active_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      last_in      = last_ff;

      if (advance) begin
         rsp_valid_in = 1'b1;
         last_in      = done_next;
         status_in    = STAT_NONE;
         if (pos_ff == POS_ECHO) begin
            kind_in = KIND_ECHO;
            data_in = job_ff.echo_byte;
         end else if (pos_ff == POS_STATUS) begin
            kind_in   = KIND_STATUS;
            data_in   = '0;
            status_in = job_ff.status;
         end else begin
            kind_in = KIND_FRAME;
            data_in = frame_byte;
         end
         if (done_next) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_follow;
         end
      end else if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         active_in = 1'b1;
         job_in    = pop_job;
         pos_in    = start_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_STATUS |-> last_ff)
      else $error("status word is not the last word of its job");

   a_plain_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_STATUS |-> status_ff == STAT_NONE)
      else $error("echo or frame word carries a status");

endmodule

@@ sv/led_command_parser_frame_gen.sv @@
// channel    dir  handshake      payload
// req_chan   in   valid/ready    func, rx_byte
// rsp_chan   out  valid/ready    kind, data_byte, status, last
//
// a byte gives 1 word, a CR 2, a color command CR 22, a rainbow-mode tick 20 words;
// the back end loads each job, then sends one word per cycle unless rsp_chan stalls
// the front end takes a word whenever the two-entry job queue has room
// synchronous active-high reset clears line store, count, colors, rainbow mode and tick
// a stalled rsp_chan holds its word; the front keeps accepting until the queue fills
module led_command_parser_frame_gen
   import lcp_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lcp_req_if.sink   req_chan,
   lcp_rsp_if.source rsp_chan
);

   // jobs from the parser to the word sequencer
   logic    push, pop, queue_full, queue_empty;
   job_type push_job, pop_job;

   // front: echo, line capture, command decode, color and tick state
   lcp_front #(
      .LINE_BYTES(LINE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // decouples parsing from word output
   lcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   // back: walks echo, frame and status words into the output register
   lcp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .pop_job (pop_job),
      .empty   (queue_empty),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

@@ dv/lcp_frame_checker.sv @@
module lcp_frame_checker
   import lcp_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   lcp_req_if   req_mon,
   lcp_rsp_if   rsp_mon,
   output int   error_count,
   output int   words_pending
);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [1:0] status;
      logic       last;
   } rsp_word_type;

   localparam logic [7:0]      CHAR_CR     = 8'h0D;
   localparam logic [7:0]      LED_HEAD    = 8'hE1;
   localparam logic [7:0]      FILL_START  = 8'h00;
   localparam logic [7:0]      FILL_END    = 8'hFF;
   localparam logic [8*12-1:0] RAINBOW_CMD = "#FULLRAINBOW";
   localparam int              SHOWN_MAX   = 10;

   rsp_word_type       expected_words[$];
   rsp_word_type       step_words[$];
   logic [7:0]         line_buf [LINE_BYTES];
   logic [COUNT_W-1:0] line_len;
   logic [7:0]         led_rgb [9];     // R6 G6 B6 R7 G7 B7 R8 G8 B8
   logic               rainbow_on;
   logic [7:0]         anim_tick;
   int                 fail_total = 0;

   function automatic logic is_upper_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c <= "9") return 4'(c - "0");
      return 4'(c - "A" + 8'd10);
   endfunction

   function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
      return {hex_value(hi), hex_value(lo)};
   endfunction

   function void add_word(input logic [1:0] kind, input logic [7:0] data,
                          input logic [1:0] status);
      rsp_word_type w;
      w = '{kind: kind, data_byte: data, status: status, last: 1'b0};
      step_words.push_back(w);
   endfunction

   function void add_led_frame(input logic [7:0] rgb [9]);
      for (int i = 0; i < 4; i++) add_word(KIND_FRAME, FILL_START, STAT_NONE);
      for (int led = 0; led < 3; led++) begin
         add_word(KIND_FRAME, LED_HEAD, STAT_NONE);
         add_word(KIND_FRAME, rgb[led*3+2], STAT_NONE);
         add_word(KIND_FRAME, rgb[led*3+1], STAT_NONE);
         add_word(KIND_FRAME, rgb[led*3], STAT_NONE);
      end
      for (int i = 0; i < 4; i++) add_word(KIND_FRAME, FILL_END, STAT_NONE);
   endfunction

   function logic colour_cmd_ok();
      if (line_buf[0] != "#") return 1'b0;
      for (int i = 1; i < 7; i++)
         if (!is_upper_hex(line_buf[i])) return 1'b0;
      if (line_buf[7] != "D") return 1'b0;
      return line_buf[8] >= "6" && line_buf[8] <= "8";
   endfunction

   function logic rainbow_cmd_ok();
      for (int i = 0; i < 12; i++)
         if (line_buf[i] != RAINBOW_CMD[8*(11-i) +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   function void close_line();
      logic [1:0] code;
      int         led;
      code = STAT_FORMAT;
      if (line_len == 13) begin
         if (rainbow_cmd_ok()) begin
            rainbow_on = 1'b1;
            code = STAT_RAINBOW;
         end
      end else if (line_len == 10 && colour_cmd_ok()) begin
         led = line_buf[8] - "6";
         led_rgb[led*3]   = hex_byte(line_buf[1], line_buf[2]);
         led_rgb[led*3+1] = hex_byte(line_buf[3], line_buf[4]);
         led_rgb[led*3+2] = hex_byte(line_buf[5], line_buf[6]);
         add_led_frame(led_rgb);
         rainbow_on = 1'b0;
         code = STAT_COLOUR;
      end
      add_word(KIND_STATUS, 8'h00, code);
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      line_len = '0;
   endfunction

   // color wheel at position 255 - tick, same color on all three leds
   function void render_wheel();
      logic [7:0] pos;
      logic [7:0] r, g, b;
      logic [7:0] rgb [9];
      pos = 8'd255 - anim_tick;
      if (pos < 8'd85) begin
         r = 8'd255 - 8'(pos * 3); g = 8'd0; b = 8'(pos * 3);
      end else if (pos < 8'd170) begin
         pos = pos - 8'd85;
         r = 8'd0; g = 8'(pos * 3); b = 8'd255 - 8'(pos * 3);
      end else begin
         pos = pos - 8'd170;
         r = 8'(pos * 3); g = 8'd255 - 8'(pos * 3); b = 8'd0;
      end
      for (int i = 0; i < 3; i++) begin
         rgb[i*3] = r; rgb[i*3+1] = g; rgb[i*3+2] = b;
      end
      add_led_frame(rgb);
   endfunction

   function void predict_word(input logic func, input logic [7:0] rx);
      step_words.delete();
      if (func) begin
         anim_tick = (anim_tick == 8'd254) ? 8'd0 : anim_tick + 8'd1;
         if (rainbow_on) render_wheel();
      end else begin
         if (line_len < COUNT_MAX) line_len = line_len + 1'b1;
         add_word(KIND_ECHO, rx, STAT_NONE);
         if (line_len <= LINE_BYTES) line_buf[line_len - 1] = rx;
         if (rx == CHAR_CR) close_line();
      end
      if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   function void clear_model();
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      foreach (led_rgb[i]) led_rgb[i] = 8'h00;
      line_len   = '0;
      rainbow_on = 1'b0;
      anim_tick  = 8'd0;
      expected_words.delete();
   endfunction

   function void note_failure(input logic have_want, input rsp_word_type want,
                              input rsp_word_type got);
      fail_total++;
      if (fail_total > SHOWN_MAX) return;
      if (have_want) begin
         $display("%0t lcp check: expected kind %0d data %02h status %0d last %0d",
                  $time, want.kind, want.data_byte, want.status, want.last);
         $display("%0t lcp check: got      kind %0d data %02h status %0d last %0d",
                  $time, got.kind, got.data_byte, got.status, got.last);
      end else begin
         $display("%0t lcp check: unexpected word kind %0d data %02h status %0d last %0d",
                  $time, got.kind, got.data_byte, got.status, got.last);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         clear_model();
      end else begin
         if (req_mon.valid && req_mon.ready) predict_word(req_mon.func, req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{kind: rsp_mon.kind, data_byte: rsp_mon.data_byte,
                    status: rsp_mon.status, last: rsp_mon.last};
            if (expected_words.size() == 0) begin
               note_failure(1'b0, got, got);
            end else begin
               want = expected_words.pop_front();
               if (got.kind != want.kind || got.data_byte != want.data_byte ||
                   got.status != want.status || got.last != want.last)
                  note_failure(1'b1, want, got);
            end
         end
      end
      words_pending <= expected_words.size();
      error_count   <= fail_total;
   end

endmodule

@@ dv/led_command_parser_frame_gen_test.sv @@
module led_command_parser_frame_gen_test;

   // a stretch this long with no word moving on either channel means a hang
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 40;
   localparam int RESET_CYCLES = 12;
   localparam int TOTAL_WORDS  = 220;
   // rainbow run long enough to cross a wheel segment boundary
   localparam int WHEEL_TICKS  = 90;

   localparam logic       FUNC_CHAR  = 1'b0;
   localparam logic       FUNC_TICK  = 1'b1;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam string      HEX_DIGITS = "0123456789ABCDEF";

   typedef enum {SEQ_COLOUR, SEQ_RAINBOW, SEQ_TICKS, SEQ_BROKEN, SEQ_LONG, SEQ_NOISE,
                 SEQ_SHORT} line_shape_type;
   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_BURSTY, DRAIN_THIRD} drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcp_req_if req_chan ();
   lcp_rsp_if rsp_chan ();

   int error_count;
   int words_pending;
   int idle_cycles = 0;
   int burst_left  = 0;
   int words_sent  = 0;

   led_command_parser_frame_gen dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // watches both channels, predicts every response word and counts mismatches
   lcp_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // one word on req_chan; the sender runs in bursts with random gaps between
   task automatic send_word(input logic func, input logic [7:0] rx);
      int gap;
      if (burst_left == 0) begin
         // a third of the bursts follow on with no gap at all
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= func;
      req_chan.rx_byte <= rx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(FUNC_CHAR, s[i]);
   endtask

   // tick carries a random byte, which the block must ignore
   task automatic send_tick();
      send_word(FUNC_TICK, 8'($urandom_range(0, 255)));
   endtask

   // sender holds off until every predicted word has come out
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // one random line or tick run; two in five are well formed commands, colors random
   task automatic send_random_line();
      logic [7:0]     text[$];
      line_shape_type shape;
      int             pick;
      int             n;
      int             pos;
      logic [7:0]     c;
      string          cmd;
      pick = $urandom_range(0, 99);
      if (pick < 30) shape = SEQ_COLOUR;
      else if (pick < 40) shape = SEQ_RAINBOW;
      else if (pick < 58) shape = SEQ_TICKS;
      else if (pick < 76) shape = SEQ_BROKEN;
      else if (pick < 86) shape = SEQ_LONG;
      else if (pick < 94) shape = SEQ_NOISE;
      else shape = SEQ_SHORT;

      case (shape)
         SEQ_TICKS: begin
            n = $urandom_range(1, 8);
            repeat (n) send_tick();
            return;
         end
         SEQ_COLOUR, SEQ_BROKEN: begin
            // half of the broken lines start from the rainbow command instead
            if (shape == SEQ_BROKEN && $urandom_range(0, 1) == 1) begin
               cmd = "#FULLRAINBOW";
               for (int i = 0; i < cmd.len(); i++) text.push_back(cmd[i]);
            end else begin
               text.push_back("#");
               repeat (6) text.push_back(HEX_DIGITS[$urandom_range(0, 15)]);
               text.push_back("D");
               text.push_back(8'("6" + $urandom_range(0, 2)));
            end
            if (shape == SEQ_BROKEN) begin
               pos = $urandom_range(0, text.size() - 1);
               case ($urandom_range(0, 3))
                  0: text[pos] = 8'("a" + $urandom_range(0, 5));    // lowercase hex
                  1: text.delete(pos);                               // one short
                  2: text.insert(pos, HEX_DIGITS[$urandom_range(0, 15)]);
                  default: begin
                     c = 8'($urandom_range(0, 255));
                     text[pos] = (c == CHAR_CR) ? "G" : c;
                  end
               endcase
            end
            text.push_back(CHAR_CR);
         end
         SEQ_RAINBOW: send_text("#FULLRAINBOW\r");
         SEQ_LONG: begin
            // around the store depth and past the count saturation
            n = $urandom_range(10, 18);
            repeat (n) begin
               c = 8'($urandom_range(0, 255));
               text.push_back((c == CHAR_CR) ? "Z" : c);
            end
            text.push_back(CHAR_CR);
         end
         SEQ_NOISE: begin
            n = $urandom_range(1, 12);
            repeat (n) begin
               if ($urandom_range(0, 7) == 0) text.push_back(CHAR_CR);
               else text.push_back(8'($urandom_range(0, 255)));
            end
         end
         default: begin
            // from a lone cr up to a line just short of a color command
            n = $urandom_range(0, 8);
            repeat (n) text.push_back(HEX_DIGITS[$urandom_range(0, 15)]);
            text.push_back(CHAR_CR);
         end
      endcase
      foreach (text[i]) send_word(FUNC_CHAR, text[i]);
   endtask

   // response side stalls on its own pattern, changing mode at random
   initial begin
      drain_mode_type mode;
      int             mode_left;
      int             run_left;
      logic           stalled;
      mode      = DRAIN_FREE;
      mode_left = 0;
      run_left  = 0;
      stalled   = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         case (mode)
            DRAIN_FREE: rsp_chan.ready <= 1'b1;
            DRAIN_COIN: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
            DRAIN_BURSTY: begin
               if (run_left == 0) begin
                  stalled  = !stalled;
                  run_left = stalled ? $urandom_range(1, 8) : $urandom_range(1, 12);
               end
               run_left--;
               rsp_chan.ready <= !stalled;
            end
            default: rsp_chan.ready <= (mode_left % 3 == 0);
         endcase
      end
   end

   // hang detection: cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("led_command_parser_frame_gen_test: errors");
      $finish;
   end

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.func    <= FUNC_CHAR;
      req_chan.rx_byte <= 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone cr, then extreme bytes ending in a line of the wrong length
      send_word(FUNC_CHAR, CHAR_CR);
      send_word(FUNC_CHAR, 8'h00);
      send_word(FUNC_CHAR, 8'hFF);
      send_word(FUNC_CHAR, CHAR_CR);
      // tick with rainbow off gives no words
      send_word(FUNC_TICK, 8'hFF);
      // color with zero, full and mixed channels on the first led
      send_text("#00FF09D6\r");
      send_text("#FULLRAINBOW\r");
      send_word(FUNC_TICK, 8'h00);

      // hold off until the block has caught up
      drain_results();

      // rainbow on: a run of wheel frames across a segment boundary
      repeat (WHEEL_TICKS) send_tick();
      drain_results();

      while (words_sent < TOTAL_WORDS) begin
         send_random_line();
         if ($urandom_range(0, 14) == 0) drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && words_pending == 0)
         $display("led_command_parser_frame_gen_test: clean");
      else
         $display("led_command_parser_frame_gen_test: errors");
      $finish;
   end

endmodule
